### rtl/hts_pkg.sv
// Shared types, codes and widths for the HRRN tick scheduler.
package hts_pkg;

  localparam int unsigned MAX_PROCS_DEF = 8;
  localparam int unsigned BURST_W       = 8;
  localparam int unsigned ARR_W         = 16;
  localparam int unsigned WAIT_W        = 16;
  localparam int unsigned SUM_W         = WAIT_W + 1;
  localparam int unsigned PROD_W        = SUM_W + BURST_W;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned RIDX_W        = 3;
  localparam int unsigned WMASK_W       = 8;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ZERO_BURST = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ARR_ORDER  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL_RHS,
    ST_CMP,
    ST_UPDATE
  } hts_state_e;

  typedef struct packed {
    logic load_lhs;
    logic load_rhs;
  } hts_mul_ctrl_t;

endpackage

### rtl/hts_ratio_unit.sv
// Shared (wait + burst) * burst multiplier with product registers and ratio compare.
module hts_ratio_unit import hts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hts_mul_ctrl_t       ctrl_i,
  input  logic [WAIT_W-1:0]   wait_i,
  input  logic [BURST_W-1:0]  add_burst_i,
  input  logic [BURST_W-1:0]  mul_burst_i,
  output logic                lhs_greater_o
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] lhs_q, lhs_d;
  logic [PROD_W-1:0] rhs_q, rhs_d;

  assign sum  = SUM_W'(wait_i) + SUM_W'(add_burst_i);
  assign prod = PROD_W'(sum) * PROD_W'(mul_burst_i);

  always_comb begin
    lhs_d = lhs_q;
    rhs_d = rhs_q;
    if (ctrl_i.load_lhs) begin
      lhs_d = prod;
    end
    if (ctrl_i.load_rhs) begin
      rhs_d = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhs_q <= '0;
      rhs_q <= '0;
    end else begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign lhs_greater_o = lhs_q > rhs_q;

endmodule

### rtl/hrrn_tick_scheduler_unit.sv
// Top level of the HRRN tick scheduler: process table, sequencer and result register.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  command | start / busy       | cmd_i, burst_time_i, arrival_time_i
//  result  | valid_o (1 cycle)  | status_o, run_valid_o, run_index_o, finished_o,
//          |                    | waiting_mask_o, tick_now_o
//
//  Add transaction: result strobes the cycle after accept; busy stays low.
//  Tick transaction: a scan pass (skipped if a process holds the CPU), then an update pass;
//  each visits the stored entries in turn and ends in a closing step, and each contending
//  entry adds MUL_RHS and CMP steps for the shared multiplier; result strobes as busy drops.
//  Reset clears the table to empty and the clock to tick 0; no clearing pass.
//  Results cannot be held off; each is valid for exactly one cycle.
module hrrn_tick_scheduler_unit import hts_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd_i,
  input  logic [BURST_W-1:0]   burst_time_i,
  input  logic [ARR_W-1:0]     arrival_time_i,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 run_valid_o,
  output logic [RIDX_W-1:0]    run_index_o,
  output logic                 finished_o,
  output logic [WMASK_W-1:0]   waiting_mask_o,
  output logic [ARR_W-1:0]     tick_now_o
);

  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned IW = $clog2(MAX_PROCS + 1);

  hts_state_e state_q, state_d;

  logic [BURST_W-1:0] burst_q [MAX_PROCS];
  logic [ARR_W-1:0]   arr_q   [MAX_PROCS];
  logic [WAIT_W-1:0]  wait_q  [MAX_PROCS];
  logic [BURST_W-1:0] run_q   [MAX_PROCS];

  logic [IW-1:0]        count_q, count_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [AW-1:0]        cur_idx_q, cur_idx_d;
  logic [ARR_W-1:0]     tick_q, tick_d;
  logic [ARR_W-1:0]     last_arr_q, last_arr_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic [BURST_W-1:0]   best_b_q, best_b_d;
  logic [WAIT_W-1:0]    best_w_q, best_w_d;
  logic                 ran_q, ran_d;
  logic                 fin_q, fin_d;
  logic [RIDX_W-1:0]    ridx_q, ridx_d;
  logic [WMASK_W-1:0]   wmask_q, wmask_d;

  logic                 valid_q, valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 run_valid_q, run_valid_d;
  logic [RIDX_W-1:0]    run_index_q, run_index_d;
  logic                 finished_q, finished_d;
  logic [WMASK_W-1:0]   waiting_mask_q, waiting_mask_d;
  logic [ARR_W-1:0]     tick_now_q, tick_now_d;

  logic [AW-1:0]        idx_a;
  logic [AW-1:0]        count_a;
  logic [31:0]          idx_ext;
  logic                 in_range;
  logic                 elig;
  logic                 accept;
  logic                 add_we;
  logic                 wait_we;
  logic                 run_we;
  logic [WAIT_W-1:0]    wait_new;
  logic [BURST_W-1:0]   run_new;
  logic [ARR_W-1:0]     add_arr;
  logic [STATUS_W-1:0]  add_status;

  hts_mul_ctrl_t        mul_ctrl;
  logic [WAIT_W-1:0]    mul_wait;
  logic [BURST_W-1:0]   mul_add_b;
  logic [BURST_W-1:0]   mul_mul_b;
  logic                 lhs_greater;

  assign idx_a    = idx_q[AW-1:0];
  assign count_a  = count_q[AW-1:0];
  assign idx_ext  = 32'(idx_q);
  assign in_range = idx_q < count_q;
  assign elig     = in_range && !done_q[idx_a] && (tick_q >= arr_q[idx_a]);
  assign accept   = start && !busy;
  assign busy     = state_q != ST_IDLE;
  assign wait_new = wait_q[idx_a] + WAIT_W'(1);
  assign run_new  = run_q[idx_a] + BURST_W'(1);
  assign add_arr  = (count_q == '0) ? '0 : arrival_time_i;

  always_comb begin
    if (burst_time_i == '0) begin
      add_status = STAT_ZERO_BURST;
    end else if (count_q != '0 && arrival_time_i <= last_arr_q) begin
      add_status = STAT_ARR_ORDER;
    end else if (count_q >= IW'(MAX_PROCS)) begin
      add_status = STAT_FULL;
    end else begin
      add_status = STAT_OK;
    end
  end

  hts_ratio_unit u_ratio (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (mul_ctrl),
    .wait_i        (mul_wait),
    .add_burst_i   (mul_add_b),
    .mul_burst_i   (mul_mul_b),
    .lhs_greater_o (lhs_greater)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_TICK) begin
          state_d = cur_valid_q ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!in_range) begin
          state_d = ST_UPDATE;
        end else if (elig && found_q) begin
          state_d = ST_MUL_RHS;
        end
      end
      ST_MUL_RHS: state_d = ST_CMP;
      ST_CMP:     state_d = ST_SCAN;
      ST_UPDATE: begin
        if (!in_range) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d        = count_q;
    idx_d          = idx_q;
    done_d         = done_q;
    cur_valid_d    = cur_valid_q;
    cur_idx_d      = cur_idx_q;
    tick_d         = tick_q;
    last_arr_d     = last_arr_q;
    found_d        = found_q;
    best_idx_d     = best_idx_q;
    best_b_d       = best_b_q;
    best_w_d       = best_w_q;
    ran_d          = ran_q;
    fin_d          = fin_q;
    ridx_d         = ridx_q;
    wmask_d        = wmask_q;
    valid_d        = 1'b0;
    status_d       = status_q;
    run_valid_d    = run_valid_q;
    run_index_d    = run_index_q;
    finished_d     = finished_q;
    waiting_mask_d = waiting_mask_q;
    tick_now_d     = tick_now_q;
    add_we         = 1'b0;
    wait_we        = 1'b0;
    run_we         = 1'b0;
    mul_ctrl       = '0;
    mul_wait       = wait_q[idx_a];
    mul_add_b      = burst_q[idx_a];
    mul_mul_b      = best_b_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_ADD) begin
            valid_d        = 1'b1;
            status_d       = add_status;
            run_valid_d    = 1'b0;
            run_index_d    = '0;
            finished_d     = 1'b0;
            waiting_mask_d = '0;
            tick_now_d     = '0;
            if (add_status == STAT_OK) begin
              add_we           = 1'b1;
              done_d[count_a]  = 1'b0;
              count_d          = count_q + IW'(1);
              last_arr_d       = add_arr;
            end
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            ran_d   = 1'b0;
            fin_d   = 1'b0;
            ridx_d  = '0;
            wmask_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!in_range) begin
          idx_d = '0;
          if (found_q) begin
            cur_valid_d = 1'b1;
            cur_idx_d   = best_idx_q;
          end
        end else if (!elig) begin
          idx_d = idx_q + IW'(1);
        end else if (!found_q) begin
          found_d    = 1'b1;
          best_idx_d = idx_a;
          best_b_d   = burst_q[idx_a];
          best_w_d   = wait_q[idx_a];
          idx_d      = idx_q + IW'(1);
        end else begin
          mul_ctrl.load_lhs = 1'b1;
        end
      end
      ST_MUL_RHS: begin
        mul_ctrl.load_rhs = 1'b1;
        mul_wait          = best_w_q;
        mul_add_b         = best_b_q;
        mul_mul_b         = burst_q[idx_a];
      end
      ST_CMP: begin
        if (lhs_greater) begin
          best_idx_d = idx_a;
          best_b_d   = burst_q[idx_a];
          best_w_d   = wait_q[idx_a];
        end
        idx_d = idx_q + IW'(1);
      end
      ST_UPDATE: begin
        if (!in_range) begin
          valid_d        = 1'b1;
          status_d       = STAT_OK;
          run_valid_d    = ran_q;
          run_index_d    = ridx_q;
          finished_d     = fin_q;
          waiting_mask_d = wmask_q;
          tick_now_d     = tick_q;
          tick_d         = tick_q + ARR_W'(1);
        end else begin
          if (elig) begin
            if (cur_valid_q && idx_a == cur_idx_q) begin
              run_we = 1'b1;
              ran_d  = 1'b1;
              ridx_d = idx_ext[RIDX_W-1:0];
              if (run_new >= burst_q[idx_a]) begin
                fin_d         = 1'b1;
                done_d[idx_a] = 1'b1;
                cur_valid_d   = 1'b0;
              end
            end else begin
              wait_we = wait_q[idx_a] != '1;
              if (idx_ext < 32'(WMASK_W)) begin
                wmask_d[idx_ext[RIDX_W-1:0]] = 1'b1;
              end
            end
          end
          idx_d = idx_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // process table
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      burst_q[count_a] <= burst_time_i;
      arr_q[count_a]   <= add_arr;
      wait_q[count_a]  <= '0;
      run_q[count_a]   <= '0;
    end else begin
      if (wait_we) begin
        wait_q[idx_a] <= wait_new;
      end
      if (run_we) begin
        run_q[idx_a] <= run_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      idx_q          <= '0;
      done_q         <= '0;
      cur_valid_q    <= 1'b0;
      cur_idx_q      <= '0;
      tick_q         <= '0;
      last_arr_q     <= '0;
      found_q        <= 1'b0;
      best_idx_q     <= '0;
      best_b_q       <= '0;
      best_w_q       <= '0;
      ran_q          <= 1'b0;
      fin_q          <= 1'b0;
      ridx_q         <= '0;
      wmask_q        <= '0;
      valid_q        <= 1'b0;
      status_q       <= '0;
      run_valid_q    <= 1'b0;
      run_index_q    <= '0;
      finished_q     <= 1'b0;
      waiting_mask_q <= '0;
      tick_now_q     <= '0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      idx_q          <= idx_d;
      done_q         <= done_d;
      cur_valid_q    <= cur_valid_d;
      cur_idx_q      <= cur_idx_d;
      tick_q         <= tick_d;
      last_arr_q     <= last_arr_d;
      found_q        <= found_d;
      best_idx_q     <= best_idx_d;
      best_b_q       <= best_b_d;
      best_w_q       <= best_w_d;
      ran_q          <= ran_d;
      fin_q          <= fin_d;
      ridx_q         <= ridx_d;
      wmask_q        <= wmask_d;
      valid_q        <= valid_d;
      status_q       <= status_d;
      run_valid_q    <= run_valid_d;
      run_index_q    <= run_index_d;
      finished_q     <= finished_d;
      waiting_mask_q <= waiting_mask_d;
      tick_now_q     <= tick_now_d;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign run_valid_o    = run_valid_q;
  assign run_index_o    = run_index_q;
  assign finished_o     = finished_q;
  assign waiting_mask_o = waiting_mask_q;
  assign tick_now_o     = tick_now_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IW'(MAX_PROCS))
    else $error("process count beyond table depth");

  a_tick_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == CMD_TICK |=> busy)
    else $error("tick transaction did not start the sequencer");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_run_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && run_valid_o |-> status_o == STAT_OK)
    else $error("tick result with non-ok status");

  a_finish_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && finished_o |-> run_valid_o)
    else $error("finish reported without a running process");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the HRRN tick scheduler: queued stimulus, scoreboard and checks.
module testbench;
  import hts_pkg::*;

  localparam int unsigned MAXP         = MAX_PROCS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 4 * MAXP + 8;

  typedef struct {
    logic               cmd;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    bit                 drain;
  } pending_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                run_valid;
    logic [RIDX_W-1:0]   run_index;
    logic                finished;
    logic [WMASK_W-1:0]  waiting_mask;
    logic [ARR_W-1:0]    tick_now;
  } sched_result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                cmd_i          = CMD_ADD;
  logic [BURST_W-1:0]  burst_time_i   = '0;
  logic [ARR_W-1:0]    arrival_time_i = '0;
  logic                busy;
  logic                valid_o;
  logic [STATUS_W-1:0] status_o;
  logic                run_valid_o;
  logic [RIDX_W-1:0]   run_index_o;
  logic                finished_o;
  logic [WMASK_W-1:0]  waiting_mask_o;
  logic [ARR_W-1:0]    tick_now_o;

  hrrn_tick_scheduler_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .burst_time_i   (burst_time_i),
    .arrival_time_i (arrival_time_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .run_valid_o    (run_valid_o),
    .run_index_o    (run_index_o),
    .finished_o     (finished_o),
    .waiting_mask_o (waiting_mask_o),
    .tick_now_o     (tick_now_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pending_item_t stimulus_q[$];
  sched_result_t expected_results[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;

  // stimulus-side bookkeeping of accepted processes
  int unsigned gen_procs    = 0;
  int unsigned gen_last_arr = 0;
  int unsigned gen_ticks    = 0;

  // scheduler state mirror
  logic [BURST_W-1:0] burst_tbl   [MAXP] = '{default: '0};
  logic [ARR_W-1:0]   arrival_tbl [MAXP] = '{default: '0};
  logic [WAIT_W-1:0]  wait_cnt    [MAXP] = '{default: '0};
  logic [BURST_W-1:0] run_cnt     [MAXP] = '{default: '0};
  logic [MAXP-1:0]    done_bits   = '0;
  int unsigned        proc_count  = 0;
  bit                 cpu_taken   = 1'b0;
  int unsigned        cpu_idx     = 0;
  logic [ARR_W-1:0]   tick_count  = '0;

  function automatic logic proc_ready(int unsigned i);
    return !done_bits[i] && (tick_count >= arrival_tbl[i]);
  endfunction

  function automatic sched_result_t sched_predict(pending_item_t it);
    sched_result_t r;
    bit            found;
    int unsigned   best;
    logic [31:0]   lhs;
    logic [31:0]   rhs;
    r = '0;
    if (it.cmd == CMD_ADD) begin
      if (it.burst == '0) begin
        r.status = STAT_ZERO_BURST;
      end else if (proc_count > 0 && it.arrival <= arrival_tbl[proc_count-1]) begin
        r.status = STAT_ARR_ORDER;
      end else if (proc_count >= MAXP) begin
        r.status = STAT_FULL;
      end else begin
        burst_tbl[proc_count]   = it.burst;
        arrival_tbl[proc_count] = (proc_count == 0) ? '0 : it.arrival;
        wait_cnt[proc_count]    = '0;
        run_cnt[proc_count]     = '0;
        done_bits[proc_count]   = 1'b0;
        proc_count++;
      end
      return r;
    end
    r.tick_now = tick_count;
    if (!cpu_taken) begin
      found = 1'b0;
      best  = 0;
      for (int unsigned i = 0; i < proc_count; i++) begin
        if (!proc_ready(i)) continue;
        if (!found) begin
          found = 1'b1;
          best  = i;
        end else begin
          lhs = (32'(wait_cnt[i]) + 32'(burst_tbl[i])) * 32'(burst_tbl[best]);
          rhs = (32'(wait_cnt[best]) + 32'(burst_tbl[best])) * 32'(burst_tbl[i]);
          if (lhs > rhs) best = i;
        end
      end
      if (found) begin
        cpu_taken = 1'b1;
        cpu_idx   = best;
      end
    end
    for (int unsigned i = 0; i < proc_count; i++) begin
      if (!proc_ready(i)) continue;
      if (cpu_taken && i == cpu_idx) begin
        r.run_valid = 1'b1;
        r.run_index = RIDX_W'(i);
        run_cnt[i]  = run_cnt[i] + 8'd1;
        if (run_cnt[i] >= burst_tbl[i]) begin
          r.finished   = 1'b1;
          done_bits[i] = 1'b1;
          cpu_taken    = 1'b0;
        end
      end else begin
        if (wait_cnt[i] != '1) wait_cnt[i] = wait_cnt[i] + 16'd1;
        r.waiting_mask[i] = 1'b1;
      end
    end
    tick_count = tick_count + 16'd1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  task automatic queue_item(logic cmd, logic [BURST_W-1:0] b, logic [ARR_W-1:0] a, bit drain);
    pending_item_t it;
    it.cmd     = cmd;
    it.burst   = b;
    it.arrival = a;
    it.drain   = drain;
    stimulus_q.push_back(it);
    if (cmd == CMD_TICK) begin
      gen_ticks++;
    end else if (b != '0 && (gen_procs == 0 || a > gen_last_arr) && gen_procs < MAXP) begin
      gen_last_arr = (gen_procs == 0) ? 0 : a;
      gen_procs++;
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left   = 0;
  bit          fire;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        expected_results.push_back(sched_predict(stimulus_q.pop_front()));
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (start && !fire) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (stimulus_q.size() == 0 ||
                   (stimulus_q[0].drain && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        start          <= 1'b1;
        cmd_i          <= stimulus_q[0].cmd;
        burst_time_i   <= stimulus_q[0].burst;
        arrival_time_i <= stimulus_q[0].arrival;
      end
    end
  end

  // monitor
  sched_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending", {30'd0, status_o}, '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (run_valid_o !== want.run_valid)
          report_mismatch("run_valid", 32'(run_valid_o), 32'(want.run_valid));
        if (run_index_o !== want.run_index)
          report_mismatch("run_index", 32'(run_index_o), 32'(want.run_index));
        if (finished_o !== want.finished)
          report_mismatch("finished", 32'(finished_o), 32'(want.finished));
        if (waiting_mask_o !== want.waiting_mask)
          report_mismatch("waiting_mask", 32'(waiting_mask_o), 32'(want.waiting_mask));
        if (tick_now_o !== want.tick_now)
          report_mismatch("tick_now", 32'(tick_now_o), 32'(want.tick_now));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned kind;
    int unsigned b;
    int unsigned a;
    bit          hold;

    // directed: rejects, idle tick, first arrival ignored, ratio tie, max burst
    queue_item(CMD_ADD, 8'd0, 16'hFFFF, 1'b0);
    queue_item(CMD_TICK, 8'd0, 16'd0, 1'b0);
    queue_item(CMD_ADD, 8'd3, 16'hFFFF, 1'b0);
    queue_item(CMD_ADD, 8'd2, 16'd0, 1'b0);
    queue_item(CMD_ADD, 8'd0, 16'd0, 1'b0);
    queue_item(CMD_ADD, 8'd2, 16'd1, 1'b0);
    queue_item(CMD_ADD, 8'd1, 16'd1, 1'b0);
    queue_item(CMD_ADD, 8'd1, 16'd2, 1'b0);
    repeat (7) queue_item(CMD_TICK, 8'hFF, 16'hFFFF, 1'b0);
    queue_item(CMD_ADD, 8'd255, 16'd8, 1'b1);
    repeat (2) queue_item(CMD_TICK, 8'd0, 16'd0, 1'b0);

    for (int n = 0; n < 380; n++) begin
      sel  = $urandom_range(0, 99);
      hold = (n % 90 == 45);
      if (sel < 18) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          queue_item(CMD_ADD, 8'd0, 16'($urandom), hold);
        end else if (kind == 1) begin
          queue_item(CMD_ADD, 8'($urandom_range(1, 255)), 16'($urandom), hold);
        end else begin
          b = (kind == 2) ? $urandom_range(1, 40) : $urandom_range(1, 12);
          a = gen_ticks + $urandom_range(0, 10);
          if (a <= gen_last_arr) a = gen_last_arr + 1;
          queue_item(CMD_ADD, 8'(b), 16'(a), hold);
        end
      end else begin
        queue_item(CMD_TICK, 8'($urandom), 16'($urandom), hold);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus_q.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("transactions left without result", expected_results.size(), 0);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
